// ----- hdl/ems_pkg.sv -----
// Shared types, operation codes and memory sizing for the execute and memory stage.
package ems_pkg;

  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  typedef logic signed [31:0] word_t;
  typedef logic [MEM_AW-1:0]  mem_idx_t;

  typedef enum logic [3:0] {
    OP_NOP  = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_ADDI = 4'd3,
    OP_SLL  = 4'd4,
    OP_SRL  = 4'd5,
    OP_AND  = 4'd6,
    OP_OR   = 4'd7,
    OP_XOR  = 4'd8,
    OP_BEQ  = 4'd9,
    OP_BNE  = 4'd10,
    OP_BLT  = 4'd11,
    OP_BGE  = 4'd12,
    OP_LW   = 4'd13,
    OP_SW   = 4'd14
  } op_t;

  typedef struct packed {
    logic [3:0] action;
    word_t      pc;
    word_t      first_value;
    word_t      second_value;
    word_t      immediate;
    word_t      store_data;
  } instr_t;

  typedef struct packed {
    word_t    result;
    logic     is_load;
    logic     mem_wr;
    logic     fault;
    mem_idx_t mem_idx;
  } exe_t;

  typedef struct packed {
    logic     rd_en;
    logic     wr_en;
    mem_idx_t idx;
    word_t    wdata;
  } mem_req_t;

endpackage

// ----- hdl/ems_in_if.sv -----
// Instruction channel carrying one instruction word per handshake.
interface ems_in_if;
  logic                valid;
  logic                ready;
  logic [3:0]          action;
  ems_pkg::word_t      pc;
  ems_pkg::word_t      first_value;
  ems_pkg::word_t      second_value;
  ems_pkg::word_t      immediate;
  ems_pkg::word_t      store_data;

  modport source (
    output valid, action, pc, first_value, second_value, immediate, store_data,
    input  ready
  );
  modport sink (
    input  valid, action, pc, first_value, second_value, immediate, store_data,
    output ready
  );
endinterface

// ----- hdl/ems_out_if.sv -----
// Result channel carrying one result word per handshake.
interface ems_out_if;
  logic           valid;
  logic           ready;
  ems_pkg::word_t result;
  logic           address_fault;

  modport source (
    output valid, result, address_fault,
    input  ready
  );
  modport sink (
    input  valid, result, address_fault,
    output ready
  );
endinterface

// ----- hdl/ems_alu.sv -----
// Arithmetic, branch target and load/store address logic for one instruction.
module ems_alu (
  input  ems_pkg::instr_t instr,
  output ems_pkg::exe_t   exe
);
  import ems_pkg::*;

  logic [31:0] a_u;
  logic [31:0] b_u;
  logic [31:0] addr;
  logic [31:0] taken_pc;
  logic [31:0] next_pc;
  logic [4:0]  sh;
  logic        in_range;
  op_t         op;

  always_comb begin
    op       = op_t'(instr.action);
    a_u      = 32'(instr.first_value);
    b_u      = 32'(instr.second_value);
    sh       = b_u[4:0];
    addr     = b_u + 32'(instr.immediate);
    taken_pc = 32'(instr.pc) + 32'(instr.immediate);
    next_pc  = 32'(instr.pc) + 32'd1;
    in_range = addr < 32'(MEM_WORDS);

    exe.result  = '0;
    exe.is_load = 1'b0;
    exe.mem_wr  = 1'b0;
    exe.fault   = 1'b0;
    exe.mem_idx = addr[MEM_AW-1:0];

    case (op)
      OP_ADD:  exe.result = word_t'(a_u + b_u);
      OP_SUB:  exe.result = word_t'(a_u - b_u);
      OP_ADDI: exe.result = word_t'(a_u + 32'(instr.immediate));
      OP_SLL:  exe.result = word_t'(a_u << sh);
      OP_SRL:  exe.result = word_t'(a_u >> sh);
      OP_AND:  exe.result = word_t'(a_u & b_u);
      OP_OR:   exe.result = word_t'(a_u | b_u);
      OP_XOR:  exe.result = word_t'(a_u ^ b_u);
      OP_BEQ:  exe.result = word_t'((a_u == b_u) ? taken_pc : next_pc);
      OP_BNE:  exe.result = word_t'((a_u != b_u) ? taken_pc : next_pc);
      OP_BLT: begin
        exe.result = word_t'((instr.first_value < instr.second_value) ? taken_pc : next_pc);
      end
      OP_BGE: begin
        exe.result = word_t'((instr.first_value >= instr.second_value) ? taken_pc : next_pc);
      end
      OP_LW: begin
        exe.fault   = !in_range;
        exe.is_load = in_range;
      end
      OP_SW: begin
        exe.fault  = !in_range;
        exe.mem_wr = in_range;
        if (in_range) begin
          exe.result = instr.store_data;
        end
      end
      default: exe.result = '0;
    endcase
  end

endmodule

// ----- hdl/ems_dmem.sv -----
// Data memory with a registered read port and a clearing pass after reset.
module ems_dmem (
  input  logic              clk,
  input  logic              rst_n,
  input  ems_pkg::mem_req_t req,
  output ems_pkg::word_t    rd_data,
  output logic              clr_busy
);
  import ems_pkg::*;

  word_t    mem [MEM_WORDS];
  word_t    rd_data_r;
  mem_idx_t clr_idx_r;
  mem_idx_t clr_idx_nxt;
  logic     clr_busy_r;
  logic     clr_busy_nxt;
  logic     wr_en;
  mem_idx_t wr_idx;
  word_t    wr_data;

  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      if (clr_idx_r == mem_idx_t'(MEM_WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + mem_idx_t'(1);
      end
    end
    wr_en   = clr_busy_r | req.wr_en;
    wr_idx  = clr_busy_r ? clr_idx_r : req.idx;
    wr_data = clr_busy_r ? '0 : req.wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_idx_r  <= clr_idx_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.idx];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

// ----- hdl/execute_and_memory_stage.sv -----
// Top level of the execute and memory stage: input register, execute logic and result register.
// The stage takes one instruction word per clock unless back pressure or the clearing pass holds
// it off: the word is held in an input register, executed and, for loads and stores, sent to the
// data memory, whose registered read port and the result register form the second stage. Back
// pressure on the result side stalls both stages but an instruction is still taken while a
// finished result waits, as long as the input register is empty. After reset the data
// memory is cleared one word per cycle, and the stage accepts no instruction until the
// clearing pass is over. Addresses below zero or at or above MEM_WORDS raise address_fault
// with a zero result and leave the memory untouched.
module execute_and_memory_stage (
  input  logic      clk,
  input  logic      rst_n,
  ems_in_if.sink    in_chan,
  ems_out_if.source out_chan
);
  import ems_pkg::*;

  instr_t   s1_r;
  logic     s1_valid_r;
  logic     s1_valid_nxt;
  logic     s2_valid_r;
  logic     s2_valid_nxt;
  word_t    s2_res_r;
  logic     s2_load_r;
  logic     s2_fault_r;
  logic     adv2;
  logic     move;
  logic     accept;
  logic     clr_busy;
  exe_t     exe;
  mem_req_t mem_req;
  word_t    rd_data;

  ems_alu u_alu (
    .instr (s1_r),
    .exe   (exe)
  );

  ems_dmem u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  always_comb begin
    adv2           = !s2_valid_r || out_chan.ready;
    move           = s1_valid_r && adv2;
    in_chan.ready  = !clr_busy && (!s1_valid_r || adv2);
    accept         = in_chan.valid && in_chan.ready;

    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end

    s2_valid_nxt = s2_valid_r;
    if (move) begin
      s2_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      s2_valid_nxt = 1'b0;
    end

    mem_req.rd_en = move && exe.is_load;
    mem_req.wr_en = move && exe.mem_wr;
    mem_req.idx   = exe.mem_idx;
    mem_req.wdata = s1_r.store_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.action       <= in_chan.action;
      s1_r.pc           <= in_chan.pc;
      s1_r.first_value  <= in_chan.first_value;
      s1_r.second_value <= in_chan.second_value;
      s1_r.immediate    <= in_chan.immediate;
      s1_r.store_data   <= in_chan.store_data;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      s2_res_r   <= exe.result;
      s2_load_r  <= exe.is_load;
      s2_fault_r <= exe.fault;
    end
  end

  assign out_chan.valid         = s2_valid_r;
  assign out_chan.result        = s2_load_r ? rd_data : s2_res_r;
  assign out_chan.address_fault = s2_fault_r;

  a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_chan.ready)
    else $error("Instruction accepted during memory clearing pass.");

  a_fault_gives_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.address_fault) |-> (out_chan.result == '0))
    else $error("Faulting access returned a non-zero result.");

  a_full_pipe_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("Input taken while both stages are full and stalled.");

  a_write_only_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> (!exe.fault && !clr_busy))
    else $error("Memory write issued for a faulting store or during clearing.");

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the execute and memory stage, with random idling on both channels.
`timescale 1ns / 100ps

module testbench;
  import ems_pkg::*;

  localparam logic [3:0] UNUSED_CODE = 4'd15;

  typedef struct packed {
    word_t result;
    logic  fault;
  } outcome_t;

  logic clk;
  logic rst_n;

  ems_in_if  in_chan ();
  ems_out_if out_chan ();

  execute_and_memory_stage DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  instr_t      instr_queue[$];
  outcome_t    expected_results[$];
  word_t       data_words[MEM_WORDS] = '{default: '0};
  instr_t      offered;
  outcome_t    oldest;
  int unsigned items_total;
  int unsigned words_accepted;
  int unsigned results_seen;
  int unsigned fail_count;
  int unsigned in_wait;
  int unsigned out_wait;
  int unsigned hold_off;
  bit          in_calm;
  bit          out_calm;

  always #5 clk = ~clk;

  function automatic outcome_t execute_instr(instr_t ins);
    outcome_t    o;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] addr;
    logic [31:0] taken;
    logic [31:0] next_pc;
    logic [4:0]  sh;
    a       = ins.first_value;
    b       = ins.second_value;
    sh      = b[4:0];
    addr    = b + ins.immediate;
    taken   = ins.pc + ins.immediate;
    next_pc = ins.pc + 32'd1;
    o       = '0;
    case (ins.action)
      OP_ADD:  o.result = a + b;
      OP_SUB:  o.result = a - b;
      OP_ADDI: o.result = a + ins.immediate;
      OP_SLL:  o.result = a << sh;
      OP_SRL:  o.result = a >> sh;
      OP_AND:  o.result = a & b;
      OP_OR:   o.result = a | b;
      OP_XOR:  o.result = a ^ b;
      OP_BEQ:  o.result = (a == b) ? taken : next_pc;
      OP_BNE:  o.result = (a != b) ? taken : next_pc;
      OP_BLT:  o.result = ($signed(a) < $signed(b)) ? taken : next_pc;
      OP_BGE:  o.result = ($signed(a) >= $signed(b)) ? taken : next_pc;
      OP_LW, OP_SW: begin
        if (addr >= MEM_WORDS) begin
          o.fault = 1'b1;
        end else if (ins.action == OP_LW) begin
          o.result = data_words[addr[MEM_AW-1:0]];
        end else begin
          data_words[addr[MEM_AW-1:0]] = ins.store_data;
          o.result                     = ins.store_data;
        end
      end
      default: o.result = '0;
    endcase
    return o;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic push_instr(logic [3:0] action, word_t pc, word_t a, word_t b, word_t imm,
                            word_t sd);
    instr_t ins;
    ins.action       = action;
    ins.pc           = pc;
    ins.first_value  = a;
    ins.second_value = b;
    ins.immediate    = imm;
    ins.store_data   = sd;
    instr_queue.push_back(ins);
  endtask

  task automatic fill_random(int unsigned count);
    logic [3:0]  action;
    word_t       a;
    word_t       b;
    word_t       imm;
    int unsigned sel;
    repeat (count) begin
      sel = $urandom_range(0, 19);
      if (sel < 15) begin
        action = 4'(sel);
      end else if (sel < 19) begin
        action = $urandom_range(0, 1) ? OP_LW : OP_SW;
      end else begin
        action = UNUSED_CODE;
      end
      a   = rand_word();
      b   = rand_word();
      imm = rand_word();
      if (action inside {OP_BEQ, OP_BNE, OP_BLT, OP_BGE} && $urandom_range(0, 2) == 0) begin
        b = a;
      end
      if (action inside {OP_LW, OP_SW}) begin
        case ($urandom_range(0, 9))
          0, 1:    imm = rand_word();
          2:       imm = MEM_WORDS + $urandom_range(0, 3) - b;
          3:       imm = -1 - $urandom_range(0, 3) - b;
          4:       imm = $urandom_range(0, MEM_WORDS - 1) - b;
          5:       imm = $urandom_range(MEM_WORDS - 4, MEM_WORDS - 1) - b;
          default: imm = $urandom_range(0, 15) - b;
        endcase
      end
      push_instr(action, rand_word(), a, b, imm, rand_word());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_wait = draw_wait(in_calm);
    end else if (!(in_chan.valid && !in_chan.ready)) begin
      if (in_chan.valid) begin
        expected_results.push_back(execute_instr(offered));
        words_accepted++;
        if ($urandom_range(0, 49) == 0) begin
          in_calm = !in_calm;
        end
        in_wait = draw_wait(in_calm);
      end
      if (in_wait > 0) begin
        in_wait--;
        in_chan.valid <= 1'b0;
      end else if (instr_queue.size() > 0) begin
        offered = instr_queue.pop_front();
        in_chan.action       <= offered.action;
        in_chan.pc           <= offered.pc;
        in_chan.first_value  <= offered.first_value;
        in_chan.second_value <= offered.second_value;
        in_chan.immediate    <= offered.immediate;
        in_chan.store_data   <= offered.store_data;
        in_chan.valid        <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_wait = draw_wait(out_calm);
      hold_off = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing outstanding: result %h, address_fault %b",
                 out_chan.result, out_chan.address_fault);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_chan.result !== oldest.result) begin
            $error("result: expected %h, actual %h", oldest.result, out_chan.result);
            fail_count++;
          end
          if (out_chan.address_fault !== oldest.fault) begin
            $error("address_fault: expected %b, actual %b", oldest.fault,
                   out_chan.address_fault);
            fail_count++;
          end
        end
        if ($urandom_range(0, 49) == 0) begin
          out_calm = !out_calm;
        end
        out_wait = draw_wait(out_calm);
        // Hold the result side off for a long while so that the stage fills and stalls.
        if (results_seen == 300 || results_seen == 900) begin
          hold_off = 150 + $urandom_range(0, 100);
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        out_chan.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.action       = OP_NOP;
    in_chan.pc           = '0;
    in_chan.first_value  = '0;
    in_chan.second_value = '0;
    in_chan.immediate    = '0;
    in_chan.store_data   = '0;
    out_chan.ready       = 1'b0;
    words_accepted       = 0;
    results_seen         = 0;
    fail_count           = 0;
    in_calm              = 1'b0;
    out_calm             = 1'b0;

    push_instr(OP_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_instr(UNUSED_CODE, $urandom, $urandom, $urandom, $urandom, $urandom);
    push_instr(OP_ADD, 0, 32'h7FFF_FFFF, 1, 0, 0);
    push_instr(OP_SUB, 0, 32'h8000_0000, 1, 0, 0);
    push_instr(OP_ADDI, 0, -1, 0, 32'h8000_0000, 0);
    push_instr(OP_SLL, 0, -1, -1, 0, 0);
    push_instr(OP_SRL, 0, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    push_instr(OP_SRL, 0, -1, 32'h0000_0020, 0, 0);
    push_instr(OP_AND, 0, 32'hAAAA_AAAA, -1, 0, 0);
    push_instr(OP_OR, 0, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0);
    push_instr(OP_XOR, 0, -1, 32'h0F0F_0F0F, 0, 0);
    push_instr(OP_BEQ, 32'h7FFF_FFFF, 5, 5, 1, 0);
    push_instr(OP_BEQ, 32'h7FFF_FFFF, 5, 6, 1, 0);
    push_instr(OP_BNE, -1, 5, 6, -8, 0);
    push_instr(OP_BNE, -1, 7, 7, -8, 0);
    push_instr(OP_BLT, 100, -1, 1, 20, 0);
    push_instr(OP_BLT, 100, 1, -1, 20, 0);
    push_instr(OP_BGE, 100, 32'h8000_0000, 32'h8000_0000, -100, 0);
    push_instr(OP_BGE, 100, 32'h8000_0000, 32'h7FFF_FFFF, -100, 0);
    push_instr(OP_SW, 0, 0, 0, 0, 32'hDEAD_BEEF);
    push_instr(OP_SW, 0, 0, MEM_WORDS - 1, 0, 32'h8000_0001);
    push_instr(OP_SW, 0, 0, MEM_WORDS - 1, 1, 32'h1234_5678);
    push_instr(OP_LW, 0, 0, 32'h7FFF_FFFF, 32'h8000_0001, 0);
    push_instr(OP_LW, 0, 0, MEM_WORDS, -1, 0);
    push_instr(OP_LW, 0, 0, -1, 0, 0);
    push_instr(OP_SW, 0, 0, 32'h7FFF_FFFF, 1, 32'h0BAD_0BAD);
    fill_random(1200);
    items_total = instr_queue.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted < items_total || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[execute_and_memory_stage] OK");
    end else begin
      $display("[execute_and_memory_stage] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[execute_and_memory_stage] ERROR");
    $finish;
  end

endmodule
